[sv/pnsl_pkg.sv]
package pnsl_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned CFG_W      = 10;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned FLOAT_W    = 32;
  localparam int unsigned EXP_W      = 8;
  localparam int unsigned MANT_W     = 23;
  localparam int unsigned EXP_BIAS   = 127;
  // largest squared distance of one byte: two nibble terms of 15*15
  localparam int unsigned BYTE_SQ_MAX = 450;
  localparam int unsigned BYTE_SQ_W   = 9;

  localparam logic [CFG_W-1:0] DIM_RESET = 10'd64;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [NIBBLE_W-1:0] nibble_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [FLOAT_W-1:0]  float_t;

  // control of the beat sitting in the read-data stage
  typedef struct packed {
    logic valid;
    logic op;
    logic last;
  } beat_ctl_t;

endpackage

[sv/packed_nibble_squared_l2.sv]
// squared L2 distance engine over vectors of packed 4-bit values, two per byte
//
// input channel (in_valid/in_ready): one byte per beat; in_op 0 writes the
// query byte at the current position, in_op 1 streams a candidate byte that is
// compared against the stored query byte at that position.  the position is
// shared by both ops and wraps after a full vector of bytes.
// config channel (cfg_valid/cfg_ready, always ready): writes the vector length
// in bytes; 0 acts as 1, values above MAX_VECTOR_BYTES act as MAX_VECTOR_BYTES.
// output channel (out_valid/out_ready): one beat per candidate vector with the
// exact squared distance as single-precision bits and the candidate index.
// throughput: one byte per cycle while in_ready is high; each beat reads or writes
// the query ram once in its accept cycle, and the ram's registered read feeds the
// accumulate stage.  result path: a candidate's result reaches out_valid after its last
// byte through the ram read with accumulate, then the float convert, each registered
// reset: position, running sum and candidate index clear, the vector length
// is 64; query bytes are undefined until loaded.
// stall: the output register and the result stage absorb a stalled receiver;
// in_ready drops only when a finished result cannot move forward
module packed_nibble_squared_l2 #(
  parameter int unsigned MAX_VECTOR_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [pnsl_pkg::BYTE_W-1:0]   in_byte_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pnsl_pkg::FLOAT_W-1:0]  out_distance_bits,
  output logic [pnsl_pkg::INDEX_W-1:0]  out_candidate_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pnsl_pkg::CFG_W-1:0]    cfg_data
);

  localparam int unsigned PW    = $clog2(MAX_VECTOR_BYTES);
  // worst-case running sum over a full vector
  localparam int unsigned SUM_W = $clog2(MAX_VECTOR_BYTES * pnsl_pkg::BYTE_SQ_MAX + 1);

  // last valid position for the current length, kept ready for the compare
  logic [PW-1:0] last_pos_r, last_pos_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   dim_wide;
  logic [31:0]   last_wide;

  // read-data stage
  pnsl_pkg::beat_ctl_t beat_r, beat_nxt;
  pnsl_pkg::byte_t     byte_r, byte_nxt;

  logic            in_acc;
  logic            is_last;
  logic            beat_go;
  pnsl_pkg::byte_t query_byte;

  logic                 res_valid;
  logic [SUM_W-1:0]     res_sum;
  pnsl_pkg::index_t     res_index;
  logic                 res_take;

  assign cfg_ready = 1'b1;

  // clamp the written length and keep its last position
  always_comb begin
    dim_wide = {{(32-pnsl_pkg::CFG_W){1'b0}}, cfg_data};
    if (dim_wide == 32'd0) begin
      last_wide = 32'd0;
    end else if (dim_wide > MAX_VECTOR_BYTES) begin
      last_wide = MAX_VECTOR_BYTES - 1;
    end else begin
      last_wide = dim_wide - 32'd1;
    end
    last_pos_nxt = (cfg_valid && cfg_ready) ? last_wide[PW-1:0] : last_pos_r;
  end

  // a beat can enter while the read-data stage is empty or draining
  assign in_ready = !beat_r.valid || beat_go;
  assign in_acc   = in_valid && in_ready;

  // a shortened length makes any position at or past its end the last byte
  assign is_last = (pos_r >= last_pos_r);

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      pos_nxt = is_last ? '0 : pos_r + 1'b1;
    end
  end

  always_comb begin
    beat_nxt = beat_r;
    byte_nxt = byte_r;
    if (in_acc) begin
      beat_nxt.valid = 1'b1;
      beat_nxt.op    = in_op;
      beat_nxt.last  = is_last;
      byte_nxt       = in_byte_value;
    end else if (beat_go) begin
      beat_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      last_pos_r   <= PW'(pnsl_pkg::DIM_RESET - 1'b1);
      beat_r.valid <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      last_pos_r   <= last_pos_nxt;
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.op   <= beat_nxt.op;
    beat_r.last <= beat_nxt.last;
    byte_r      <= byte_nxt;
  end

  // query store: query beats write, candidate beats read, one access per beat;
  // a read always lands in a later cycle than any earlier write
  pnsl_ram #(
    .WIDTH (pnsl_pkg::BYTE_W),
    .DEPTH (MAX_VECTOR_BYTES)
  ) u_query_ram (
    .clk   (clk),
    .we    (in_acc && (in_op == pnsl_pkg::OP_QUERY)),
    .waddr (pos_r),
    .wdata (in_byte_value),
    .re    (in_acc && (in_op == pnsl_pkg::OP_CAND)),
    .raddr (pos_r),
    .rdata (query_byte)
  );

  pnsl_accum #(
    .SUM_W (SUM_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat_r),
    .cand_byte  (byte_r),
    .query_byte (query_byte),
    .beat_go    (beat_go),
    .res_valid  (res_valid),
    .res_sum    (res_sum),
    .res_index  (res_index),
    .res_take   (res_take)
  );

  pnsl_tofloat #(
    .SUM_W (SUM_W)
  ) u_tofloat (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_sum   (res_sum),
    .res_index (res_index),
    .res_take  (res_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_bits  (out_distance_bits),
    .out_index (out_candidate_index)
  );

endmodule

[sv/pnsl_ram.sv]
module pnsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/pnsl_accum.sv]
module pnsl_accum #(
  parameter int unsigned SUM_W = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pnsl_pkg::beat_ctl_t beat,
  input  pnsl_pkg::byte_t   cand_byte,
  input  pnsl_pkg::byte_t   query_byte,
  output logic              beat_go,
  output logic              res_valid,
  output logic [SUM_W-1:0]  res_sum,
  output pnsl_pkg::index_t  res_index,
  input  logic              res_take
);

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  pnsl_pkg::index_t  cnt_r, cnt_nxt;
  logic              res_v_r, res_v_nxt;
  logic [SUM_W-1:0]  res_sum_r, res_sum_nxt;
  pnsl_pkg::index_t  res_idx_r, res_idx_nxt;

  pnsl_pkg::nibble_t ad_lo, ad_hi;
  logic [2*pnsl_pkg::NIBBLE_W-1:0] sq_lo, sq_hi;
  logic [pnsl_pkg::BYTE_SQ_W-1:0]  sq_sum;
  logic [SUM_W-1:0]  total;
  logic              emit;

  // absolute nibble differences, then squares
  always_comb begin
    ad_lo = (cand_byte[3:0] >= query_byte[3:0]) ? cand_byte[3:0] - query_byte[3:0]
                                                 : query_byte[3:0] - cand_byte[3:0];
    ad_hi = (cand_byte[7:4] >= query_byte[7:4]) ? cand_byte[7:4] - query_byte[7:4]
                                                 : query_byte[7:4] - cand_byte[7:4];
    sq_lo  = ad_lo * ad_lo;
    sq_hi  = ad_hi * ad_hi;
    sq_sum = {1'b0, sq_lo} + {1'b0, sq_hi};
    total  = sum_r + {{(SUM_W-pnsl_pkg::BYTE_SQ_W){1'b0}}, sq_sum};
  end

  assign emit    = (beat.op == pnsl_pkg::OP_CAND) && beat.last;
  assign beat_go = beat.valid && (!emit || !res_v_r || res_take);

  always_comb begin
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    res_sum_nxt = res_sum_r;
    res_idx_nxt = res_idx_r;
    res_v_nxt   = res_take ? 1'b0 : res_v_r;
    if (beat_go) begin
      if (beat.op == pnsl_pkg::OP_QUERY) begin
        // query beat drops any partial candidate
        sum_nxt = '0;
        if (beat.last) begin
          cnt_nxt = '0;
        end
      end else if (beat.last) begin
        res_v_nxt   = 1'b1;
        res_sum_nxt = total;
        res_idx_nxt = cnt_r;
        cnt_nxt     = cnt_r + 1'b1;
        sum_nxt     = '0;
      end else begin
        sum_nxt = total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      res_v_r <= res_v_nxt;
    end
    res_sum_r <= res_sum_nxt;
    res_idx_r <= res_idx_nxt;
  end

  assign res_valid = res_v_r;
  assign res_sum   = res_sum_r;
  assign res_index = res_idx_r;

endmodule

[sv/pnsl_tofloat.sv]
module pnsl_tofloat #(
  parameter int unsigned SUM_W = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  logic [SUM_W-1:0]  res_sum,
  input  pnsl_pkg::index_t  res_index,
  output logic              res_take,
  output logic              out_valid,
  input  logic              out_ready,
  output pnsl_pkg::float_t  out_bits,
  output pnsl_pkg::index_t  out_index
);

  localparam int unsigned MSB_W = $clog2(SUM_W);

  logic              ov_r, ov_nxt;
  pnsl_pkg::float_t  bits_r, bits_nxt;
  pnsl_pkg::index_t  idx_r, idx_nxt;

  logic [MSB_W-1:0]          msb;
  logic [pnsl_pkg::MANT_W:0] mant;
  logic [pnsl_pkg::EXP_W-1:0] expo;
  pnsl_pkg::float_t          fbits;

  // sum fits in the mantissa, so the conversion is exact: left shift only
  always_comb begin
    msb = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (res_sum[i]) begin
        msb = MSB_W'(i);
      end
    end
    mant  = {{(pnsl_pkg::MANT_W+1-SUM_W){1'b0}}, res_sum} << (pnsl_pkg::MANT_W - msb);
    expo  = pnsl_pkg::EXP_W'(pnsl_pkg::EXP_BIAS) + {{(pnsl_pkg::EXP_W-MSB_W){1'b0}}, msb};
    fbits = (res_sum == '0) ? '0 : {1'b0, expo, mant[pnsl_pkg::MANT_W-1:0]};
  end

  assign res_take = res_valid && (!ov_r || out_ready);

  always_comb begin
    ov_nxt   = ov_r;
    bits_nxt = bits_r;
    idx_nxt  = idx_r;
    if (res_take) begin
      ov_nxt   = 1'b1;
      bits_nxt = fbits;
      idx_nxt  = res_index;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    bits_r <= bits_nxt;
    idx_r  <= idx_nxt;
  end

  assign out_valid = ov_r;
  assign out_bits  = bits_r;
  assign out_index = idx_r;

endmodule
